// ----- rtl/sli_pkg.sv -----
// Shared types and constants for the sorted leaf insert and search block.
`default_nettype none
package sli_pkg;

  localparam int unsigned NODE_COUNT    = 256;
  localparam int unsigned KEYS_PER_NODE = 16;
  localparam int unsigned KEY_BITS      = 32;

  localparam int unsigned NODE_W  = $clog2(NODE_COUNT);
  localparam int unsigned SLOT_W  = $clog2(KEYS_PER_NODE);
  localparam int unsigned CNT_W   = $clog2(KEYS_PER_NODE + 1);
  localparam int unsigned IDX_W   = SLOT_W + 2;
  localparam int unsigned KADDR_W = NODE_W + SLOT_W;
  localparam int unsigned KEY_DEPTH = NODE_COUNT * KEYS_PER_NODE;

  // fixed field widths of the stream items
  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned ECHO_W  = 8;
  localparam int unsigned KEYF_W  = 32;
  localparam int unsigned STAT_W  = 1;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CNTF_W  = 5;

  localparam int unsigned IN_BITS     = ECHO_W + KEYF_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = STAT_W + ECHO_W + POS_W + CNTF_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 1'b0,
    STAT_FULL = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SHIFT,
    ST_PUT,
    ST_SEARCH,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/sli_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module sli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/sorted_leaf_insert_search.sv -----
// Top level: leaf node store with sorted insert and binary search.
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | node_index[7:0], key_value[39:8]                | func[0]
//  m_axis   | out | status[0], node_echo[8:1], position[13:9],      | -
//           |     | count_after[18:14]                              |
//
// One item at a time. Search: probes <= 5 for 16 keys. Insert shifts each
// larger key up one slot, then puts the new key; a full node is refused. The
// shift goes through the single read port of the key memory, one key per cycle.
// Reset clears the count valid flags at once; key memory is never cleared.
// A new item is taken while the last result waits on m_axis; a second finished
// result waits in the done state until the output register frees up.
`default_nettype none
module sorted_leaf_insert_search
  import sli_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // node_index, key_value
  input  wire logic [FUNC_W-1:0]      s_axis_tuser,   // func
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // status, node_echo, position, count_after
);

  state_e state_q, state_d;

  func_e                    func_q;
  logic [NODE_W-1:0]        node_q;
  logic signed [KEY_BITS-1:0] key_q;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [SLOT_W-1:0]        mid_q, mid_d;
  logic signed [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic                     res_status_q, res_status_d;
  logic signed [POS_W-1:0]  res_pos_q, res_pos_d;
  logic [CNT_W-1:0]         res_count_q, res_count_d;

  logic                     out_valid_q;
  logic [STAT_W-1:0]        out_status_q;
  logic [ECHO_W-1:0]        out_echo_q;
  logic [POS_W-1:0]         out_pos_q;
  logic [CNTF_W-1:0]        out_count_q;

  logic [NODE_COUNT-1:0]    cnt_valid_q;

  logic                     in_acc;
  logic                     done_go;

  // key memory ports
  logic                     key_we, key_re;
  logic [SLOT_W-1:0]        key_wslot, key_rslot;
  logic [KEY_BITS-1:0]      key_wdata;
  logic [KEY_BITS-1:0]      key_rdata_raw;
  logic signed [KEY_BITS-1:0] key_rdata;

  // count memory ports
  logic                     cnt_we;
  logic [CNT_W-1:0]         cnt_rdata;

  logic [CNT_W-1:0]         cnt_cur, cnt_m1, cnt_half;
  logic                     node_full;
  logic                     shift_less, srch_eq, srch_lt, srch_miss;
  logic signed [IDX_W-1:0]  mid_ext, lo_nx, hi_nx, lo_hi_sum;
  logic [SLOT_W-1:0]        mid_nx;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign done_go = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE);

  // ---------------- shared datapath terms ----------------
  assign cnt_cur   = cnt_valid_q[node_q] ? cnt_rdata : '0;
  assign cnt_m1    = cnt_cur - CNT_W'(1);
  assign cnt_half  = cnt_m1 >> 1;
  assign node_full = (cnt_cur >= CNT_W'(KEYS_PER_NODE));

  assign key_rdata  = signed'(key_rdata_raw);
  assign shift_less = key_q < key_rdata;
  assign srch_eq    = key_rdata == key_q;
  assign srch_lt    = key_rdata < key_q;

  assign mid_ext   = signed'(IDX_W'(mid_q));
  assign lo_nx     = srch_lt ? (mid_ext + IDX_W'(1)) : lo_q;
  assign hi_nx     = srch_lt ? hi_q : (mid_ext - IDX_W'(1));
  assign srch_miss = lo_nx > hi_nx;
  assign lo_hi_sum = lo_nx + hi_nx;   // both non-negative while lo <= hi
  assign mid_nx    = lo_hi_sum[SLOT_W:1];

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (func_q == FUNC_INSERT) begin
          if (node_full)            state_d = ST_DONE;
          else if (cnt_cur == '0)   state_d = ST_PUT;
          else                      state_d = ST_SHIFT;
        end else begin
          if (cnt_cur == '0)        state_d = ST_DONE;
          else                      state_d = ST_SEARCH;
        end
      end
      ST_SHIFT: begin
        if (!shift_less)                 state_d = ST_DONE;
        else if (slot_q == SLOT_W'(1))   state_d = ST_PUT;
      end
      ST_PUT: state_d = ST_DONE;
      ST_SEARCH: begin
        if (srch_eq || srch_miss) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (done_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs: memory ports and working registers ----------------
  always_comb begin
    key_we       = 1'b0;
    key_re       = 1'b0;
    key_wslot    = slot_q;
    key_rslot    = slot_q;
    key_wdata    = key_q;
    cnt_we       = 1'b0;
    slot_d       = slot_q;
    mid_d        = mid_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_count_d  = res_count_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_COUNT: begin
        res_pos_d    = '1;
        res_status_d = (func_q == FUNC_INSERT) && node_full;
        res_count_d  = cnt_cur;
        slot_d       = cnt_cur[SLOT_W-1:0];
        lo_d         = '0;
        hi_d         = signed'(IDX_W'(cnt_cur)) - IDX_W'(1);
        mid_d        = cnt_half[SLOT_W-1:0];
        if (func_q == FUNC_INSERT) begin
          if (!node_full) begin
            res_count_d = cnt_cur + CNT_W'(1);
            if (cnt_cur != '0) begin
              key_re    = 1'b1;
              key_rslot = cnt_m1[SLOT_W-1:0];
            end
          end
        end else if (cnt_cur != '0) begin
          key_re    = 1'b1;
          key_rslot = cnt_half[SLOT_W-1:0];
        end
      end
      ST_SHIFT: begin
        key_we = 1'b1;
        if (shift_less) begin
          // move the larger key up one slot, fetch the next one down
          key_wdata = key_rdata_raw;
          slot_d    = slot_q - SLOT_W'(1);
          if (slot_q != SLOT_W'(1)) begin
            key_re    = 1'b1;
            key_rslot = slot_q - SLOT_W'(2);
          end
        end else begin
          res_pos_d = signed'(POS_W'(slot_q));
        end
      end
      ST_PUT: begin
        key_we    = 1'b1;
        res_pos_d = signed'(POS_W'(slot_q));
      end
      ST_SEARCH: begin
        lo_d  = lo_nx;
        hi_d  = hi_nx;
        mid_d = mid_nx;
        if (srch_eq) begin
          res_pos_d = signed'(POS_W'(mid_q));
        end else if (!srch_miss) begin
          key_re    = 1'b1;
          key_rslot = mid_nx;
        end
      end
      ST_DONE: begin
        cnt_we = done_go && (func_q == FUNC_INSERT) && !res_status_q;
      end
      default: ;
    endcase
  end

  // ---------------- memories ----------------
  sli_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i ({node_q, key_wslot}),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i ({node_q, key_rslot}),
    .rdata_o (key_rdata_raw)
  );

  sli_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NODE_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (node_q),
    .wdata_i (res_count_q),
    .re_i    (in_acc),
    .raddr_i (s_axis_tdata[NODE_W-1:0]),
    .rdata_o (cnt_rdata)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (cnt_we) cnt_valid_q[node_q] <= 1'b1;
      if (done_go)            out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(s_axis_tuser);
      node_q <= s_axis_tdata[NODE_W-1:0];
      key_q  <= signed'(s_axis_tdata[ECHO_W +: KEY_BITS]);
    end
    slot_q       <= slot_d;
    mid_q        <= mid_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_count_q  <= res_count_d;
    if (done_go) begin
      out_status_q <= res_status_q ? STAT_FULL : STAT_DONE;
      out_echo_q   <= node_q;
      out_pos_q    <= res_pos_q;
      out_count_q  <= res_count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0),
                          out_count_q, out_pos_q, out_echo_q, out_status_q};

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (res_count_q <= CNT_W'(KEYS_PER_NODE)))
    else $error("count written beyond node capacity");

  a_ins_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_go && (func_q == FUNC_INSERT) && !res_status_q)
      |-> (!res_pos_q[POS_W-1] && (CNT_W'(unsigned'(res_pos_q)) < res_count_q)))
    else $error("insert slot not below new count");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_we && key_re) |-> (key_wslot != key_rslot))
    else $error("key read and write hit the same slot");

endmodule
`default_nettype wire
